@@ hdl/path_grouping_by_key_unit_assert.svh @@
// assertion macros for the path grouping unit
// depends on a clock named clk and an active-low reset named arst_n in scope
`ifndef PATH_GROUPING_BY_KEY_UNIT_ASSERT_SVH
`define PATH_GROUPING_BY_KEY_UNIT_ASSERT_SVH

// clocked property, ignored while reset is asserted
`define PGBK_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define PGBK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/pgbk_pkg.sv @@
// shared types and codes for the path grouping unit
// no dependencies
package pgbk_pkg;

	localparam int KEY_W  = 64;
	localparam int IDX_W  = 6;
	localparam int CFG_W  = 2;
	localparam int CFGA_W = 1;

	// register indexes
	localparam logic [CFGA_W-1:0] CFG_GROUPING_MODE  = 1'd0;
	localparam logic [CFGA_W-1:0] CFG_MARGINAL_SPLIT = 1'd1;

	// grouping modes
	localparam logic [1:0] MODE_ALL_ONE = 2'd0;
	localparam logic [1:0] MODE_EACH    = 2'd1;
	localparam logic [1:0] MODE_BY_KEY  = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0] path_key;
		logic             is_marginal;
		logic             last_path;
	} path_t;

	typedef struct packed {
		logic [IDX_W-1:0] group_index;
		logic             new_group;
		logic             table_full;
	} result_t;

	// stored group entry
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             marginal;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic finish;
		logic hit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic skip;
		logic match;
		logic at_last;
	} dp_status_t;

endpackage

@@ hdl/pgbk_ctrl.sv @@
// scan sequencer for the path grouping unit
// depends on pgbk_pkg
module pgbk_ctrl #(
	parameter int SLOT_CAP = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  pgbk_pkg::dp_status_t        status,
	output pgbk_pkg::ctrl_cmd_t         cmd,
	output logic [$clog2(SLOT_CAP)-1:0] rd_addr,
	output logic [$clog2(SLOT_CAP)-1:0] scan_idx
);
	import pgbk_pkg::*;

	localparam int AW = $clog2(SLOT_CAP);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic          state_q;
	logic          state_d;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] idx_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cmd     = '0;
		rd_addr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					idx_d    = '0;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_addr = idx_q + AW'(1);
				if (status.skip) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else if (status.match) begin
					cmd.finish = 1'b1;
					cmd.hit    = 1'b1;
					state_d    = ST_IDLE;
				end else if (status.at_last) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					idx_d = idx_q + AW'(1);
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	assign busy     = (state_q == ST_SCAN);
	assign scan_idx = idx_q;

endmodule

@@ hdl/pgbk_datapath.sv @@
// group table, key compare and result register for the path grouping unit
// depends on pgbk_pkg
module pgbk_datapath #(
	parameter int SLOT_CAP = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [pgbk_pkg::CFGA_W-1:0] cfg_idx,
	input  logic [pgbk_pkg::CFG_W-1:0]  cfg_data,
	input  pgbk_pkg::path_t             path,
	input  pgbk_pkg::ctrl_cmd_t         cmd,
	input  logic [$clog2(SLOT_CAP)-1:0] rd_addr,
	input  logic [$clog2(SLOT_CAP)-1:0] scan_idx,
	output pgbk_pkg::dp_status_t        status,
	output pgbk_pkg::result_t           result,
	output logic                        done
);
	import pgbk_pkg::*;

	localparam int AW = $clog2(SLOT_CAP);
	localparam int CW = $clog2(SLOT_CAP + 1);

	entry_t          mem [SLOT_CAP];
	entry_t          rd_data_q;
	logic [KEY_W-1:0] key_q;
	logic            marg_q;
	logic            last_q;
	logic [1:0]      mode_q;
	logic            split_q;
	logic [CW-1:0]   count_q;
	result_t         result_q;
	logic            done_q;
	logic            key_ok;
	logic            marg_ok;
	logic            has_room;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_BY_KEY;
			split_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_GROUPING_MODE:  mode_q  <= cfg_data;
				CFG_MARGINAL_SPLIT: split_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// path beat capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q  <= path.path_key;
			marg_q <= path.is_marginal;
			last_q <= path.last_path;
		end
	end

	// group table, one registered read per cycle
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
		if (cmd.finish && !cmd.hit && has_room) begin
			mem[count_q[AW-1:0]] <= '{key: key_q, marginal: marg_q};
		end
	end

	// compare against the registered table entry at scan_idx, and derive room, skip and last-entry flags
	always_comb begin
		key_ok         = (mode_q == MODE_ALL_ONE) || (rd_data_q.key == key_q);
		marg_ok        = !split_q || (rd_data_q.marginal == marg_q);
		has_room       = (count_q < CW'(SLOT_CAP));
		status.skip    = (mode_q == MODE_EACH) || (count_q == '0);
		status.match   = key_ok && marg_ok;
		status.at_last = ((CW'(scan_idx) + CW'(1)) == count_q);
	end

	// group count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.finish) begin
				if (last_q) begin
					count_q <= '0;
				end else if (!cmd.hit && has_room) begin
					count_q <= count_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (cmd.hit) begin
				result_q.group_index <= IDX_W'(scan_idx);
				result_q.new_group   <= 1'b0;
				result_q.table_full  <= 1'b0;
			end else if (has_room) begin
				result_q.group_index <= IDX_W'(count_q);
				result_q.new_group   <= 1'b1;
				result_q.table_full  <= 1'b0;
			end else begin
				result_q.group_index <= IDX_W'(SLOT_CAP - 1);
				result_q.new_group   <= 1'b0;
				result_q.table_full  <= 1'b1;
			end
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

@@ hdl/path_grouping_by_key_unit.sv @@
// top level of the path grouping unit: controller plus datapath
// depends on pgbk_pkg, pgbk_ctrl and pgbk_datapath
//
// A path beat is taken when start is high and busy is low. The path is then compared
// with the open groups one table entry per cycle while busy is high, up to and
// including the match, or through every stored entry (at most the slot count,
// min(MAX_GROUPS, 64)) when nothing matches; in one-path-per-group mode or with an
// empty table no entry is compared and a new group is opened while there is room.
// The scan rate is set by the single read port of the group table. The result shows
// on result for exactly one cycle with done high, the first cycle after busy falls,
// and a new beat can be taken in that cycle; the receiver cannot stall it and must
// take it then.
// Configuration writes are taken at any edge with cfg_we high.
module path_grouping_by_key_unit #(
	parameter int MAX_GROUPS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [pgbk_pkg::CFGA_W-1:0] cfg_idx,
	input  logic [pgbk_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        start,
	input  pgbk_pkg::path_t             path,
	output logic                        busy,
	output logic                        done,
	output pgbk_pkg::result_t           result
);
	import pgbk_pkg::*;

	localparam int SLOT_CAP = (MAX_GROUPS < 64) ? MAX_GROUPS : 64;
	localparam int AW       = $clog2(SLOT_CAP);

	ctrl_cmd_t  cmd;
	dp_status_t status;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] scan_idx;

	pgbk_ctrl #(
		.SLOT_CAP(SLOT_CAP)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.status   (status),
		.cmd      (cmd),
		.rd_addr  (rd_addr),
		.scan_idx (scan_idx)
	);

	pgbk_datapath #(
		.SLOT_CAP(SLOT_CAP)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.path     (path),
		.cmd      (cmd),
		.rd_addr  (rd_addr),
		.scan_idx (scan_idx),
		.status   (status),
		.result   (result),
		.done     (done)
	);

endmodule

@@ hdl/pgbk_checker.sv @@
// port-level checks for the path grouping unit, bound to the top level
// depends on pgbk_pkg and path_grouping_by_key_unit_assert.svh
`include "path_grouping_by_key_unit_assert.svh"

module pgbk_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input pgbk_pkg::result_t result
);
	import pgbk_pkg::*;

	// an accepted beat starts a scan
	`PGBK_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not start a scan")

	// end of a scan always delivers a result beat
	`PGBK_ASSERT(a_fall_done, $fell(busy) |-> done, "scan ended without a result beat")

	// result beats are never back to back
	`PGBK_ASSERT_NEXT(a_done_gap, done, !done, "two result beats in a row")

	// a result beat is shown only while idle
	`PGBK_ASSERT(a_done_idle, done |-> !busy, "result beat while busy")

	// a saturated index never claims a new group
	`PGBK_ASSERT(a_full_excl, done |-> !(result.new_group && result.table_full),
		"new group and table full together")

endmodule

bind path_grouping_by_key_unit pgbk_checker u_pgbk_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
